// ===== rtl/core/rqe_pkg.sv =====
// shared constants, types and command/status structs of the rotating queue
`timescale 1ns / 1ps
`default_nettype none
package rqe_pkg;

  localparam int MAX_IDS       = 1024;
  localparam int OUTSIDE_DEPTH = 16;
  localparam int PEND_DEPTH    = MAX_IDS + OUTSIDE_DEPTH;
  localparam int ID_W          = 32;
  localparam int CFG_W         = 11;
  localparam int RING_W        = $clog2(MAX_IDS);
  localparam int NODE_W        = $clog2(MAX_IDS + OUTSIDE_DEPTH);
  localparam int CNT_W         = $clog2(MAX_IDS + 1);
  localparam int PLEN_W        = $clog2(MAX_IDS + OUTSIDE_DEPTH + 1);
  localparam int LVL_W         = $clog2(OUTSIDE_DEPTH + 1);
  localparam int OIDX_W        = (OUTSIDE_DEPTH > 1) ? $clog2(OUTSIDE_DEPTH) : 1;

  typedef enum logic [3:0] {
    ST_NONE,
    ST_ACCEPT,
    ST_INIT,
    ST_E_RD,
    ST_E_UPD,
    ST_E_PUSH,
    ST_S_RD,
    ST_S_UPD
  } step_t;

  typedef struct packed {
    step_t step;
  } rqe_cmd_t;

  typedef struct packed {
    logic init_last;
    logic drop;
  } rqe_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/rqe_ctrl.sv =====
// sequencing state machine of the rotating queue
`timescale 1ns / 1ps
`default_nettype none
module rqe_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic                start,
  input  wire logic                op,
  input  wire rqe_pkg::rqe_status_t status,
  output rqe_pkg::rqe_cmd_t        cmd,
  output logic                     busy
);
  import rqe_pkg::*;

  typedef enum logic [6:0] {
    IDLE   = 7'b0000001,
    INIT   = 7'b0000010,
    E_RD   = 7'b0000100,
    E_UPD  = 7'b0001000,
    E_PUSH = 7'b0010000,
    S_RD   = 7'b0100000,
    S_UPD  = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd.step   = ST_NONE;
    unique case (state)
      IDLE: begin
        if (cfg_we) begin
          state_next = INIT;
        end else if (start) begin
          cmd.step   = ST_ACCEPT;
          state_next = op ? S_RD : E_RD;
        end
      end
      INIT: begin
        cmd.step = ST_INIT;
        if (status.init_last && !cfg_we) state_next = IDLE;
      end
      E_RD: begin
        cmd.step   = ST_E_RD;
        state_next = E_UPD;
      end
      E_UPD: begin
        cmd.step   = ST_E_UPD;
        state_next = status.drop ? IDLE : E_PUSH;
      end
      E_PUSH: begin
        cmd.step   = ST_E_PUSH;
        state_next = IDLE;
      end
      S_RD: begin
        cmd.step   = ST_S_RD;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.step   = ST_S_UPD;
        state_next = IDLE;
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= INIT;
    else     state <= state_next;
  end

  assign busy = (state != IDLE);

endmodule
`default_nettype wire

// ===== rtl/core/rqe_dp.sv =====
// link memories, pending stack, outside slots and pointers of the rotating queue
`timescale 1ns / 1ps
`default_nettype none
module rqe_dp (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [rqe_pkg::CFG_W-1:0] cfg_data,
  input  wire logic [rqe_pkg::ID_W-1:0] person_id,
  input  wire rqe_pkg::rqe_cmd_t        cmd,
  output rqe_pkg::rqe_status_t          status,
  output logic                          served_valid,
  output logic [rqe_pkg::ID_W-1:0]      served_id
);
  import rqe_pkg::*;

  // ring and pending link memories, pending flag per inside id
  logic [RING_W-1:0] next_mem [MAX_IDS];
  logic [RING_W-1:0] prev_mem [MAX_IDS];
  logic              flag_mem [MAX_IDS];
  logic [NODE_W-1:0] pup_mem  [PEND_DEPTH];
  logic [NODE_W-1:0] pdn_mem  [PEND_DEPTH];

  logic [RING_W-1:0] nxt_q, prv_q;
  logic              flag_q;
  logic [NODE_W-1:0] pup_q, pdn_q;

  logic [CNT_W-1:0]  n;
  logic [RING_W-1:0] head, tail, init_cnt;
  logic [CNT_W-1:0]  ring_len;
  logic [NODE_W-1:0] ptop, pbot, x;
  logic [PLEN_W-1:0] plen;
  logic [LVL_W-1:0]  olevel;
  logic [ID_W-1:0]   id_r;
  logic [ID_W-1:0]   out_val [OUTSIDE_DEPTH];
  logic [OUTSIDE_DEPTH-1:0] out_vld;

  logic              in_ring, match_any, found;
  logic [OIDX_W-1:0] midx, aidx, xo;
  logic [NODE_W-1:0] xn;
  logic [RING_W-1:0] s, ps;
  logic [ID_W-1:0]   pop_val;
  logic [31:0]       cfg_wide;

  // memory port controls
  logic              ring_n_we, ring_p_we, flag_we, pup_we, pdn_we, flag_wd;
  logic [RING_W-1:0] ring_n_wa, ring_n_wd, ring_p_wa, ring_p_wd, flag_wa, ring_ra;
  logic [NODE_W-1:0] pup_wa, pup_wd, pdn_wa, pdn_wd, pend_ra;

  assign cfg_wide = 32'(cfg_data);
  assign in_ring  = (id_r != '0) && (id_r <= ID_W'(n));
  assign s        = x[RING_W-1:0];
  assign xo       = OIDX_W'(x - NODE_W'(MAX_IDS));
  assign ps       = ptop[RING_W-1:0];

  always_comb begin
    match_any = 1'b0;
    midx      = '0;
    aidx      = '0;
    for (int k = OUTSIDE_DEPTH - 1; k >= 0; k--) begin
      if (out_vld[k] && out_val[k] == id_r) begin
        match_any = 1'b1;
        midx      = OIDX_W'(k);
      end
      if (!out_vld[k]) aidx = OIDX_W'(k);
    end
  end

  always_comb begin
    if (in_ring)        xn = NODE_W'(id_r - 32'd1);
    else if (match_any) xn = NODE_W'(MAX_IDS) + NODE_W'(midx);
    else                xn = NODE_W'(MAX_IDS) + NODE_W'(aidx);
  end

  assign found = in_ring ? flag_q : match_any;
  assign status.drop      = !found && !in_ring && (olevel == LVL_W'(OUTSIDE_DEPTH));
  assign status.init_last = (init_cnt == RING_W'(MAX_IDS - 1));

  always_comb begin
    if (ptop < NODE_W'(MAX_IDS)) pop_val = ID_W'(ptop) + 32'd1;
    else pop_val = out_val[OIDX_W'(ptop - NODE_W'(MAX_IDS))];
  end

  always_comb begin
    ring_n_we = 1'b0; ring_n_wa = '0; ring_n_wd = '0;
    ring_p_we = 1'b0; ring_p_wa = '0; ring_p_wd = '0;
    flag_we   = 1'b0; flag_wa   = '0; flag_wd   = 1'b0;
    pup_we    = 1'b0; pup_wa    = '0; pup_wd    = '0;
    pdn_we    = 1'b0; pdn_wa    = '0; pdn_wd    = '0;
    ring_ra   = (cmd.step == ST_S_RD) ? head : xn[RING_W-1:0];
    pend_ra   = (cmd.step == ST_S_RD) ? ptop : xn;
    case (cmd.step)
      ST_INIT: begin
        ring_n_we = 1'b1; ring_n_wa = init_cnt; ring_n_wd = init_cnt + 1'b1;
        ring_p_we = 1'b1; ring_p_wa = init_cnt; ring_p_wd = init_cnt - 1'b1;
        flag_we   = 1'b1; flag_wa   = init_cnt; flag_wd   = 1'b0;
      end
      ST_E_UPD: begin
        if (found) begin
          // take the node out of the pending order
          if (x != ptop) begin
            pdn_we = 1'b1; pdn_wa = pup_q; pdn_wd = pdn_q;
          end
          if (x != pbot) begin
            pup_we = 1'b1; pup_wa = pdn_q; pup_wd = pup_q;
          end
        end else if (in_ring) begin
          flag_we = 1'b1; flag_wa = s; flag_wd = 1'b1;
          if (ring_len != '0) begin
            if (s != head) begin
              ring_n_we = 1'b1; ring_n_wa = prv_q; ring_n_wd = nxt_q;
            end
            if (s != tail) begin
              ring_p_we = 1'b1; ring_p_wa = nxt_q; ring_p_wd = prv_q;
            end
          end
        end
      end
      ST_E_PUSH: begin
        pdn_we = 1'b1; pdn_wa = x; pdn_wd = ptop;
        if (plen != '0) begin
          pup_we = 1'b1; pup_wa = ptop; pup_wd = x;
        end
      end
      ST_S_UPD: begin
        if (plen != '0) begin
          if (ptop < NODE_W'(MAX_IDS)) begin
            flag_we = 1'b1; flag_wa = ps; flag_wd = 1'b0;
            if (ring_len != '0) begin
              ring_n_we = 1'b1; ring_n_wa = tail; ring_n_wd = ps;
              ring_p_we = 1'b1; ring_p_wa = ps;   ring_p_wd = tail;
            end
          end
        end else if (ring_len > CNT_W'(1)) begin
          ring_n_we = 1'b1; ring_n_wa = tail; ring_n_wd = head;
          ring_p_we = 1'b1; ring_p_wa = head; ring_p_wd = tail;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ring_n_we) next_mem[ring_n_wa] <= ring_n_wd;
    if (ring_p_we) prev_mem[ring_p_wa] <= ring_p_wd;
    if (flag_we)   flag_mem[flag_wa]   <= flag_wd;
    if (pup_we)    pup_mem[pup_wa]     <= pup_wd;
    if (pdn_we)    pdn_mem[pdn_wa]     <= pdn_wd;
    nxt_q  <= next_mem[ring_ra];
    prv_q  <= prev_mem[ring_ra];
    flag_q <= flag_mem[ring_ra];
    pup_q  <= pup_mem[pend_ra];
    pdn_q  <= pdn_mem[pend_ra];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.step == ST_ACCEPT) begin
      id_r <= person_id;
    end
    if (cmd.step == ST_E_RD) x <= xn;
    if (cmd.step == ST_E_UPD && !found && !in_ring && !status.drop) out_val[xo] <= id_r;
    if (cmd.step == ST_S_UPD) begin
      if (plen != '0)          served_id <= pop_val;
      else if (ring_len != '0) served_id <= ID_W'(head) + 32'd1;
      else                     served_id <= '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      n            <= CNT_W'(MAX_IDS);
      init_cnt     <= '0;
      served_valid <= 1'b0;
      plen         <= '0;
      olevel       <= '0;
      out_vld      <= '0;
      ring_len     <= '0;
      head         <= '0;
      tail         <= '0;
      ptop         <= '0;
      pbot         <= '0;
    end else begin
      served_valid <= (cmd.step == ST_S_UPD);
      if (cfg_we) begin
        if (cfg_data == '0)                      n <= CNT_W'(1);
        else if (cfg_wide > 32'(MAX_IDS))        n <= CNT_W'(MAX_IDS);
        else                                     n <= CNT_W'(cfg_data);
        init_cnt <= '0;
      end else if (cmd.step == ST_INIT) begin
        init_cnt <= init_cnt + 1'b1;
      end
      case (cmd.step)
        ST_INIT: begin
          head     <= '0;
          tail     <= RING_W'(n - CNT_W'(1));
          ring_len <= n;
          plen     <= '0;
          olevel   <= '0;
          out_vld  <= '0;
        end
        ST_E_UPD: begin
          if (found) begin
            if (x == ptop) ptop <= pdn_q;
            if (x == pbot) pbot <= pup_q;
            plen <= plen - 1'b1;
          end else if (in_ring) begin
            if (ring_len != '0) begin
              if (s == head) head <= nxt_q;
              if (s == tail) tail <= prv_q;
              ring_len <= ring_len - 1'b1;
            end
          end else if (!status.drop) begin
            olevel      <= olevel + 1'b1;
            out_vld[xo] <= 1'b1;
          end
        end
        ST_E_PUSH: begin
          if (plen == '0) pbot <= x;
          ptop <= x;
          plen <= plen + 1'b1;
        end
        ST_S_UPD: begin
          if (plen != '0) begin
            ptop <= pdn_q;
            plen <= plen - 1'b1;
            if (ptop < NODE_W'(MAX_IDS)) begin
              if (ring_len == '0) head <= ps;
              tail     <= ps;
              ring_len <= ring_len + 1'b1;
            end else begin
              if (olevel != '0) olevel <= olevel - 1'b1;
              out_vld[OIDX_W'(ptop - NODE_W'(MAX_IDS))] <= 1'b0;
            end
          end else if (ring_len > CNT_W'(1)) begin
            head <= nxt_q;
            tail <= head;
          end
        end
        default: ;
      endcase
    end
  end

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    olevel <= LVL_W'(OUTSIDE_DEPTH)) else $error("outside level overflow");
  a_level_match: assert property (@(posedge clk) disable iff (rst)
    32'(olevel) == $countones(out_vld)) else $error("outside level and slots disagree");
  a_ring_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.step == ST_INIT) || (ring_len <= n)) else $error("ring longer than id count");
  a_strobe_pulse: assert property (@(posedge clk) disable iff (rst)
    served_valid |=> !served_valid) else $error("result strobe held");

endmodule
`default_nettype wire

// ===== rtl/core/rotating_queue_with_expedite_top.sv =====
// top level of the rotating service queue with expedite
`timescale 1ns / 1ps
`default_nettype none
// rotating service queue: ids 1..active_count are served round robin, a serve
// transfer (op = 1) returns the id at the head and moves it to the tail, an
// expedite transfer (op = 0) puts person_id in front of everything waiting,
// newest expedite first. an id above active_count is served once from a
// 16-entry outside stack and then forgotten; when that stack is full a new
// outside expedite is dropped. a transfer is taken when start is high and busy
// is low. the result of a serve is on served_id for exactly one cycle with
// served_valid high, registered at the end of the serve update step; there is
// no way to stall it, so capture it when the strobe is seen. busy stays high
// while the link memories are read and then written: a serve through its read
// and update steps, an expedite through read, update and push, and a dropped
// expedite through read and update. after reset and after every write of
// active_count (cfg_we with cfg_data) the link memories are rebuilt in a pass
// over all 1024 entries during which busy stays high; write the register only
// while the block is idle.
module rotating_queue_with_expedite_top (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [rqe_pkg::CFG_W-1:0] cfg_data,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      op,
  input  wire logic [rqe_pkg::ID_W-1:0]  person_id,
  output logic                           served_valid,
  output logic [rqe_pkg::ID_W-1:0]       served_id
);
  import rqe_pkg::*;

  // command and status between sequencer and datapath
  rqe_cmd_t    cmd;
  rqe_status_t status;

  rqe_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .cfg_we (cfg_we),
    .start  (start),
    .op     (op),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  rqe_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .person_id    (person_id),
    .cmd          (cmd),
    .status       (status),
    .served_valid (served_valid),
    .served_id    (served_id)
  );

endmodule
`default_nettype wire
